>>> rtl/assert_macros.svh
// assertion macros used by the scanline_background_renderer rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SBR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define SBR_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) else $error(msg);
`else
`define SBR_ASSERT(lbl, clk, rstn, prop, msg)
`define SBR_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

>>> rtl/sbr_pkg.sv
// types, codes and default sizes for the scanline background renderer
// no dependencies
package sbr_pkg;

  localparam int SCREEN_WIDTH_DEF  = 160;
  localparam int LINE_DOTS_DEF     = 456;
  localparam int VISIBLE_LINES_DEF = 144;
  localparam int SCAN_DOTS_DEF     = 40;
  localparam int FIFO_DEPTH_DEF    = 16;

  localparam int VRAM_AW  = 13;
  localparam int VRAM_DEPTH = 1 << VRAM_AW;
  localparam int DOT_W    = 9;
  localparam int LINE_W   = 8;
  localparam int END_LINE_EXTRA = 9;

  localparam logic [VRAM_AW-1:0] MAP_BASE     = 13'h1800;
  localparam logic [VRAM_AW-1:0] SIGNED_BASE  = 13'h0800;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] CFG_TILE_SEL   = 2'd0;
  localparam logic [1:0] CFG_SCROLL_Y   = 2'd1;
  localparam logic [1:0] CFG_BG_PALETTE = 2'd2;
  localparam logic [1:0] CFG_LY_COMPARE = 2'd3;

  typedef enum logic [1:0] {
    MODE_SCAN   = 2'd0,
    MODE_XFER   = 2'd1,
    MODE_HBLANK = 2'd2,
    MODE_VBLANK = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FETCH_ID   = 2'd0,
    FETCH_LO   = 2'd1,
    FETCH_HI   = 2'd2,
    FETCH_PUSH = 2'd3
  } fetch_step_t;

  typedef struct packed {
    logic               op;
    logic [VRAM_AW-1:0] vram_addr;
    logic [7:0]         vram_data;
  } in_word_t;

  typedef struct packed {
    logic              pixel_valid;
    logic [1:0]        pixel_shade;
    logic              line_done;
    logic              frame_start_vblank;
    logic              line_match;
    logic [1:0]        mode;
    logic [LINE_W-1:0] line;
  } out_word_t;

endpackage

>>> rtl/scanline_background_renderer.sv
// scanline background renderer top level: video ram, timing, tile fetcher, pixel fifo
// depends on sbr_pkg and assert_macros.svh
//
// One word per clock is taken on the input channel while in_stall is low, either a dot tick or
// a video ram byte write, and every word gives exactly one result word, formed combinationally
// and registered in the result register or the skid entry. The tile fetcher reads the 8 KiB
// video ram through one registered read port; each byte passes the read register into the
// fetcher's id or tile registers before the fetcher's next step, which comes only on every
// second tick. A two-entry output stage (result register plus skid) lets the block keep
// taking words while a result waits; in_stall is high only while the skid entry is full. The
// video ram has no reset and no clearing pass: read a location only after writing it.
`include "assert_macros.svh"
module scanline_background_renderer #(
  parameter int SCREEN_WIDTH  = sbr_pkg::SCREEN_WIDTH_DEF,
  parameter int LINE_DOTS     = sbr_pkg::LINE_DOTS_DEF,
  parameter int VISIBLE_LINES = sbr_pkg::VISIBLE_LINES_DEF,
  parameter int SCAN_DOTS     = sbr_pkg::SCAN_DOTS_DEF,
  parameter int FIFO_DEPTH    = sbr_pkg::FIFO_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sbr_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output sbr_pkg::out_word_t out_word,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  localparam int CW  = $clog2(FIFO_DEPTH + 1);
  localparam int PXW = $clog2(SCREEN_WIDTH + 1);
  localparam int END_LINE = VISIBLE_LINES + sbr_pkg::END_LINE_EXTRA;

  // configuration
  logic       tile_sel_r;
  logic [7:0] scroll_y_r;
  logic [7:0] bg_palette_r;
  logic [7:0] ly_compare_r;

  // timing state
  sbr_pkg::mode_t                 mode_r, mode_nxt;
  logic [sbr_pkg::DOT_W-1:0]      dot_r, dot_nxt, dot_inc;
  logic [sbr_pkg::LINE_W-1:0]     line_r, line_nxt;
  logic [PXW-1:0]                 px_r, px_nxt, px_inc;
  logic [2:0]                     row_in_tile_r, row_in_tile_nxt;
  logic [4:0]                     map_row_r, map_row_nxt;
  logic [7:0]                     scroll_line;

  // fetcher and fifo state
  sbr_pkg::fetch_step_t step_r, step_nxt, rd_kind_r;
  logic                 half_r, half_nxt;
  logic [4:0]           tile_col_r, tile_col_nxt;
  logic [7:0]           fetched_id_r;
  logic [7:0][1:0]      tile_pix_r;
  logic [1:0]           fifo_r [FIFO_DEPTH];
  logic [1:0]           fifo_nxt [FIFO_DEPTH];
  logic [CW-1:0]        fifo_cnt_r, fifo_cnt_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic                 pop;
  logic [1:0]           pop_color;

  // video ram
  logic [7:0]                   vram [sbr_pkg::VRAM_DEPTH];
  logic [7:0]                   vram_q_r;
  logic [sbr_pkg::VRAM_AW-1:0]  rd_addr, map_addr, plane_base;

  // handshake and result
  logic                 accept, tick, out_take;
  logic                 done, vblank_hit;
  sbr_pkg::out_word_t   res;
  sbr_pkg::out_word_t   out_word_r, skid_word_r;
  logic                 out_valid_r, skid_valid_r;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign tick      = accept && (in_word.op == sbr_pkg::OP_TICK);
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign dot_inc     = dot_r + 1'b1;
  assign px_inc      = px_r + 1'b1;
  assign scroll_line = scroll_y_r + line_r;

  assign map_addr = sbr_pkg::MAP_BASE | {3'b000, map_row_r, tile_col_r};
  // both planes share the base; plane bit is the lsb
  assign plane_base = tile_sel_r ? {1'b0, fetched_id_r, row_in_tile_r, 1'b0}
                                 : sbr_pkg::SIGNED_BASE +
                                   {1'b0, fetched_id_r ^ 8'h80, row_in_tile_r, 1'b0};

  // fetcher and fifo
  always_comb begin : fetch_comb
    int          j;
    logic [2:0]  k;
    half_nxt     = half_r;
    step_nxt     = step_r;
    tile_col_nxt = tile_col_r;
    fifo_nxt     = fifo_r;
    fifo_cnt_nxt = fifo_cnt_r;
    rd_pend_nxt  = 1'b0;
    rd_addr      = map_addr;
    pop          = 1'b0;
    k            = 3'd0;
    if (tick && mode_r == sbr_pkg::MODE_XFER) begin
      if (!half_r) begin
        half_nxt = 1'b1;
      end else begin
        half_nxt = 1'b0;
        case (step_r)
          sbr_pkg::FETCH_ID: begin
            rd_addr     = map_addr;
            rd_pend_nxt = 1'b1;
            step_nxt    = sbr_pkg::FETCH_LO;
          end
          sbr_pkg::FETCH_LO: begin
            rd_addr     = plane_base;
            rd_pend_nxt = 1'b1;
            step_nxt    = sbr_pkg::FETCH_HI;
          end
          sbr_pkg::FETCH_HI: begin
            rd_addr     = plane_base | {{(sbr_pkg::VRAM_AW-1){1'b0}}, 1'b1};
            rd_pend_nxt = 1'b1;
            step_nxt    = sbr_pkg::FETCH_PUSH;
          end
          sbr_pkg::FETCH_PUSH: begin
            // push waits for room, retried on the next fetching tick
            if (fifo_cnt_r <= CW'(8)) begin
              for (j = 0; j < FIFO_DEPTH; j++) begin
                if (j >= int'(fifo_cnt_r) && j < int'(fifo_cnt_r) + 8) begin
                  k = 3'(j - int'(fifo_cnt_r));
                  fifo_nxt[j] = tile_pix_r[3'd7 - k];
                end
              end
              fifo_cnt_nxt = fifo_cnt_r + CW'(8);
              tile_col_nxt = tile_col_r + 1'b1;
              step_nxt     = sbr_pkg::FETCH_ID;
            end
          end
          default: step_nxt = sbr_pkg::FETCH_ID;
        endcase
      end
      if (fifo_cnt_nxt != '0) begin
        pop = 1'b1;
        for (j = 0; j < FIFO_DEPTH - 1; j++) begin
          fifo_nxt[j] = fifo_nxt[j + 1];
        end
        fifo_cnt_nxt = fifo_cnt_nxt - 1'b1;
      end
    end
    if (tick && mode_r == sbr_pkg::MODE_SCAN && dot_inc >= sbr_pkg::DOT_W'(SCAN_DOTS)) begin
      step_nxt     = sbr_pkg::FETCH_ID;
      tile_col_nxt = 5'd0;
      fifo_cnt_nxt = '0;
    end
  end

  // popped colour is the head after this tick's push
  assign pop_color = (fifo_cnt_r == '0) ? tile_pix_r[7] : fifo_r[0];

  // next state of the line timing
  always_comb begin : state_comb
    mode_nxt        = mode_r;
    dot_nxt         = dot_r;
    line_nxt        = line_r;
    px_nxt          = px_r;
    row_in_tile_nxt = row_in_tile_r;
    map_row_nxt     = map_row_r;
    if (tick) begin
      dot_nxt = dot_inc;
      case (mode_r)
        sbr_pkg::MODE_SCAN: begin
          if (dot_inc >= sbr_pkg::DOT_W'(SCAN_DOTS)) begin
            px_nxt          = '0;
            row_in_tile_nxt = scroll_line[2:0];
            map_row_nxt     = scroll_line[7:3];
            mode_nxt        = sbr_pkg::MODE_XFER;
          end
        end
        sbr_pkg::MODE_XFER: begin
          if (pop) begin
            px_nxt = px_inc;
            if (px_inc >= PXW'(SCREEN_WIDTH)) begin
              mode_nxt = sbr_pkg::MODE_HBLANK;
            end
          end
        end
        sbr_pkg::MODE_HBLANK: begin
          if (dot_inc >= sbr_pkg::DOT_W'(LINE_DOTS)) begin
            dot_nxt  = '0;
            line_nxt = line_r + 1'b1;
            if (line_nxt == sbr_pkg::LINE_W'(VISIBLE_LINES)) begin
              mode_nxt = sbr_pkg::MODE_VBLANK;
            end else begin
              mode_nxt = sbr_pkg::MODE_SCAN;
            end
          end
        end
        sbr_pkg::MODE_VBLANK: begin
          if (dot_inc >= sbr_pkg::DOT_W'(LINE_DOTS)) begin
            dot_nxt  = '0;
            line_nxt = line_r + 1'b1;
            if (line_nxt >= sbr_pkg::LINE_W'(END_LINE)) begin
              line_nxt = '0;
              mode_nxt = sbr_pkg::MODE_SCAN;
            end
          end
        end
        default: mode_nxt = sbr_pkg::MODE_SCAN;
      endcase
    end
  end

  // result word
  always_comb begin : out_comb
    done       = tick && mode_r == sbr_pkg::MODE_XFER && pop && px_inc >= PXW'(SCREEN_WIDTH);
    vblank_hit = tick && mode_r == sbr_pkg::MODE_HBLANK && mode_nxt == sbr_pkg::MODE_VBLANK;
    res.pixel_valid        = pop;
    res.pixel_shade        = pop ? 2'(bg_palette_r >> {pop_color, 1'b0}) : 2'd0;
    res.line_done          = done;
    res.frame_start_vblank = vblank_hit;
    res.line_match         = tick && (line_r == ly_compare_r);
    res.mode               = mode_nxt;
    res.line               = line_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_sel_r   <= 1'b1;
      scroll_y_r   <= 8'd0;
      bg_palette_r <= 8'd252;
      ly_compare_r <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        sbr_pkg::CFG_TILE_SEL:   tile_sel_r   <= cfg_data[0];
        sbr_pkg::CFG_SCROLL_Y:   scroll_y_r   <= cfg_data;
        sbr_pkg::CFG_BG_PALETTE: bg_palette_r <= cfg_data;
        sbr_pkg::CFG_LY_COMPARE: ly_compare_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // video ram: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && in_word.op == sbr_pkg::OP_WRITE) begin
      vram[in_word.vram_addr] <= in_word.vram_data;
    end
    vram_q_r <= vram[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= sbr_pkg::MODE_SCAN;
      dot_r         <= '0;
      line_r        <= '0;
      px_r          <= '0;
      row_in_tile_r <= 3'd0;
      map_row_r     <= 5'd0;
      step_r        <= sbr_pkg::FETCH_ID;
      half_r        <= 1'b0;
      tile_col_r    <= 5'd0;
      fifo_cnt_r    <= '0;
      rd_pend_r     <= 1'b0;
      rd_kind_r     <= sbr_pkg::FETCH_ID;
    end else begin
      rd_pend_r <= rd_pend_nxt;
      if (rd_pend_nxt) begin
        rd_kind_r <= step_r;
      end
      if (accept) begin
        mode_r        <= mode_nxt;
        dot_r         <= dot_nxt;
        line_r        <= line_nxt;
        px_r          <= px_nxt;
        row_in_tile_r <= row_in_tile_nxt;
        map_row_r     <= map_row_nxt;
        step_r        <= step_nxt;
        half_r        <= half_nxt;
        tile_col_r    <= tile_col_nxt;
        fifo_cnt_r    <= fifo_cnt_nxt;
      end
    end
  end

  // fetched bytes land here from the registered read port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetched_id_r <= 8'd0;
      tile_pix_r   <= '0;
    end else if (rd_pend_r) begin
      case (rd_kind_r)
        sbr_pkg::FETCH_ID: fetched_id_r <= vram_q_r;
        sbr_pkg::FETCH_LO: begin
          for (int i = 0; i < 8; i++) begin
            tile_pix_r[i] <= {1'b0, vram_q_r[i]};
          end
        end
        sbr_pkg::FETCH_HI: begin
          for (int i = 0; i < 8; i++) begin
            tile_pix_r[i][1] <= vram_q_r[i];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fifo_r <= fifo_nxt;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_word_r <= skid_valid_r ? skid_word_r : res;
    end else if (accept) begin
      skid_word_r <= res;
    end
  end

  `SBR_ASSERT(a_skid_behind_out, clk, rst_n, !skid_valid_r || out_valid_r, "skid entry full while result register empty")
  `SBR_ASSERT(a_fifo_bound, clk, rst_n, fifo_cnt_r <= CW'(FIFO_DEPTH), "pixel fifo count beyond depth")
  `SBR_ASSERT_NEXT(a_fetch_spacing, clk, rst_n, rd_pend_r, !rd_pend_r, "video ram fetch reads on adjacent cycles")
  `SBR_ASSERT(a_pixel_mode, clk, rst_n, !out_valid_r || !out_word_r.pixel_valid || out_word_r.mode == sbr_pkg::MODE_XFER || out_word_r.mode == sbr_pkg::MODE_HBLANK, "pixel word outside pixel transfer")
  `SBR_ASSERT(a_fetch_in_xfer, clk, rst_n, !rd_pend_nxt || mode_r == sbr_pkg::MODE_XFER, "fetch read outside pixel transfer")

endmodule

>>> test/scanline_background_renderer_test.sv
`timescale 1ns / 1ps
// self-checking bench for scanline_background_renderer: video ram loading, line and frame
// timing, tile fetch and palette mapping checked word by word; depends on sbr_pkg and the renderer
module scanline_background_renderer_test;
  import sbr_pkg::*;

  localparam int SCREEN_W    = SCREEN_WIDTH_DEF;
  localparam int LINE_D      = LINE_DOTS_DEF;
  localparam int VISIBLE_L   = VISIBLE_LINES_DEF;
  localparam int SCAN_D      = SCAN_DOTS_DEF;
  localparam int FIFO_D      = FIFO_DEPTH_DEF;
  localparam int PHASE_WORDS = 13500;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 64;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  scanline_background_renderer #(
    .SCREEN_WIDTH (SCREEN_W),
    .LINE_DOTS    (LINE_D),
    .VISIBLE_LINES(VISIBLE_L),
    .SCAN_DOTS    (SCAN_D),
    .FIFO_DEPTH   (FIFO_D)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // words seen straight after reset: scan mode, line 0, line 0 matches the reset compare value
  localparam out_word_t L0_WRITE = '{1'b0, 2'd0, 1'b0, 1'b0, 1'b0, MODE_SCAN, 8'd0};
  localparam out_word_t L0_TICK  = '{1'b0, 2'd0, 1'b0, 1'b0, 1'b1, MODE_SCAN, 8'd0};

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t want;
  } opening_row_t;

  localparam int OPENING_ROWS = 12;
  localparam opening_row_t OPENING [OPENING_ROWS] = '{
    '{'{OP_TICK,  13'h0000, 8'h00}, 1'b1, L0_TICK},
    '{'{OP_WRITE, 13'h0000, 8'h00}, 1'b1, L0_WRITE},
    '{'{OP_WRITE, 13'h1fff, 8'hff}, 1'b1, L0_WRITE},
    '{'{OP_TICK,  13'h1fff, 8'hff}, 1'b1, L0_TICK},
    '{'{OP_WRITE, 13'h1555, 8'haa}, 1'b1, L0_WRITE},
    '{'{OP_WRITE, 13'h0aaa, 8'h55}, 1'b1, L0_WRITE},
    '{'{OP_TICK,  13'h1555, 8'haa}, 1'b1, L0_TICK},
    '{'{OP_WRITE, 13'h1800, 8'hff}, 1'b1, L0_WRITE},
    '{'{OP_WRITE, 13'h1bff, 8'h80}, 1'b1, L0_WRITE},
    '{'{OP_TICK,  13'h0aaa, 8'h55}, 1'b1, L0_TICK},
    '{'{OP_WRITE, 13'h0fff, 8'h01}, 1'b1, L0_WRITE},
    '{'{OP_TICK,  13'h0000, 8'h00}, 1'b1, L0_TICK}
  };

  // renderer copy: registers and state
  logic        tile_sel = 1'b1;
  logic [7:0]  scy = 8'd0;
  logic [7:0]  bgp = 8'd252;
  logic [7:0]  lyc = 8'd0;
  logic [7:0]  vram_copy [VRAM_DEPTH];
  mode_t       cur_mode = MODE_SCAN;
  logic [8:0]  dots = '0;
  logic [7:0]  line_no = '0;
  logic [7:0]  pixels_done = '0;
  fetch_step_t fetch_at = FETCH_ID;
  logic        fetch_half = 1'b0;
  logic [4:0]  tile_col = '0;
  logic [4:0]  map_row = '0;
  logic [2:0]  row_in_tile = '0;
  logic [7:0]  fetched_id = '0;
  logic [1:0]  tile_px [8] = '{default: 2'd0};
  logic [1:0]  fifo_q [FIFO_D];
  int          fifo_fill = 0;

  out_word_t   renderer_words_due [$];
  int          mismatches = 0;
  int          send_gap_pct;
  int          recv_stall_pct;
  bit          squeeze_req = 1'b0;

  function automatic logic [VRAM_AW-1:0] plane_addr(input logic plane);
    logic [7:0]         sid;
    logic [VRAM_AW-1:0] base;
    sid = fetched_id + 8'h80;
    if (tile_sel) begin
      base = {1'b0, fetched_id, 4'h0};
    end else begin
      base = SIGNED_BASE + {1'b0, sid, 4'h0};
    end
    return base + {row_in_tile, plane};
  endfunction

  function automatic out_word_t renderer_step(input in_word_t w);
    out_word_t  r;
    logic [7:0] y;
    logic [7:0] plane;
    logic [1:0] c;
    int         i;
    r = '0;
    if (w.op == OP_WRITE) begin
      vram_copy[w.vram_addr] = w.vram_data;
    end else begin
      dots = dots + 1'b1;
      r.line_match = (line_no == lyc);
      case (cur_mode)
        MODE_SCAN: begin
          if (dots >= SCAN_D) begin
            pixels_done = '0;
            y = scy + line_no;
            row_in_tile = y[2:0];
            map_row = y[7:3];
            tile_col = '0;
            fetch_at = FETCH_ID;
            fifo_fill = 0;
            cur_mode = MODE_XFER;
          end
        end
        MODE_XFER: begin
          // fetcher moves one step every second tick; its phase survives line changes
          if (!fetch_half) begin
            fetch_half = 1'b1;
          end else begin
            fetch_half = 1'b0;
            case (fetch_at)
              FETCH_ID: begin
                fetched_id = vram_copy[MAP_BASE + {map_row, tile_col}];
                fetch_at = FETCH_LO;
              end
              FETCH_LO: begin
                plane = vram_copy[plane_addr(1'b0)];
                for (i = 0; i < 8; i++) tile_px[i] = {1'b0, plane[i]};
                fetch_at = FETCH_HI;
              end
              FETCH_HI: begin
                plane = vram_copy[plane_addr(1'b1)];
                for (i = 0; i < 8; i++) tile_px[i][1] = plane[i];
                fetch_at = FETCH_PUSH;
              end
              default: begin
                // push waits while the fifo is too full
                if (fifo_fill <= 8 && fifo_fill + 8 <= FIFO_D) begin
                  for (i = 0; i < 8; i++) fifo_q[fifo_fill + i] = tile_px[7 - i];
                  fifo_fill += 8;
                  tile_col = tile_col + 1'b1;
                  fetch_at = FETCH_ID;
                end
              end
            endcase
          end
          if (fifo_fill > 0) begin
            c = fifo_q[0];
            for (i = 0; i < FIFO_D - 1; i++) fifo_q[i] = fifo_q[i + 1];
            fifo_fill--;
            r.pixel_valid = 1'b1;
            r.pixel_shade = bgp[2 * c +: 2];
            pixels_done = pixels_done + 1'b1;
            if (pixels_done >= SCREEN_W) begin
              r.line_done = 1'b1;
              cur_mode = MODE_HBLANK;
            end
          end
        end
        MODE_HBLANK: begin
          if (dots >= LINE_D) begin
            dots = '0;
            line_no = line_no + 1'b1;
            if (line_no == VISIBLE_L) begin
              r.frame_start_vblank = 1'b1;
              cur_mode = MODE_VBLANK;
            end else begin
              cur_mode = MODE_SCAN;
            end
          end
        end
        default: begin
          if (dots >= LINE_D) begin
            dots = '0;
            line_no = line_no + 1'b1;
            if (line_no >= VISIBLE_L + END_LINE_EXTRA) begin
              line_no = '0;
              cur_mode = MODE_SCAN;
            end
          end
        end
      endcase
    end
    r.mode = cur_mode;
    r.line = line_no;
    return r;
  endfunction

  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    bit        took;
    out_word_t model;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !in_stall;
      if (took) begin
        model = renderer_step(w);
        renderer_words_due.push_back(typed ? want : model);
      end
      @(posedge clk);
    end
  endtask

  // registers change only once every word in flight has come back
  task automatic set_registers(input logic sel, input logic [7:0] scroll, pal, cmp);
    in_valid <= 1'b0;
    while (renderer_words_due.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TILE_SEL;
    cfg_data <= {7'd0, sel};
    @(posedge clk);
    cfg_index <= CFG_SCROLL_Y;
    cfg_data <= scroll;
    @(posedge clk);
    cfg_index <= CFG_BG_PALETTE;
    cfg_data <= pal;
    @(posedge clk);
    cfg_index <= CFG_LY_COMPARE;
    cfg_data <= cmp;
    @(posedge clk);
    cfg_we <= 1'b0;
    tile_sel = sel;
    scy = scroll;
    bgp = pal;
    lyc = cmp;
  endtask

  initial begin : stimulus
    in_word_t w;
    int       phase;
    int       n;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_TILE_SEL;
    cfg_data <= '0;
    send_gap_pct = 20;
    recv_stall_pct = 49;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (n = 0; n < OPENING_ROWS; n++) begin
      send_word(OPENING[n].word, OPENING[n].typed, OPENING[n].want);
    end
    // fill the whole video ram before the first fetch can read it
    for (n = 0; n < VRAM_DEPTH; n++) begin
      w = '{OP_WRITE, VRAM_AW'(n), 8'($urandom_range(255))};
      send_word(w, 1'b0, '0);
    end
    for (phase = 0; phase < 6; phase++) begin
      send_gap_pct = (phase < 2) ? 20 : (phase < 4) ? 49 : 0;
      recv_stall_pct = (phase < 2) ? 49 : (phase < 4) ? 20 : 0;
      case (phase)
        0: set_registers(1'b1, 8'd0, 8'he4, 8'd5);
        1: set_registers(1'b0, 8'd255, 8'h1b, 8'd40);
        2: set_registers(1'b0, 8'd7, 8'h00, 8'd255);
        3: set_registers(1'b1, 8'd129, 8'hff, 8'd100);
        4: set_registers(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'd120);
        default: set_registers(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'd0);
      endcase
      if (phase == 4) squeeze_req = 1'b1;
      for (n = 0; n < PHASE_WORDS; n++) begin
        w.op = ($urandom_range(15) == 0) ? OP_WRITE : OP_TICK;
        // half the writes land in the tile map so ids keep changing
        w.vram_addr = $urandom_range(1) ? MAP_BASE + VRAM_AW'($urandom_range(1023))
                                        : VRAM_AW'($urandom_range(VRAM_DEPTH - 1));
        w.vram_data = 8'($urandom_range(255));
        send_word(w, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    while (renderer_words_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    int        hold_left;
    bit        squeezed;
    out_word_t want;
    hold_left = 0;
    squeezed = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeezed) begin
        hold_left = HOLD_CYCLES;
        squeezed = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (renderer_words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result word with nothing due: %h", out_word);
        end else begin
          want = renderer_words_due.pop_front();
          if (out_word.pixel_valid !== want.pixel_valid ||
              out_word.pixel_shade !== want.pixel_shade ||
              out_word.line_done !== want.line_done ||
              out_word.frame_start_vblank !== want.frame_start_vblank ||
              out_word.line_match !== want.line_match ||
              out_word.mode !== want.mode ||
              out_word.line !== want.line) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch want v%b s%0d d%b vb%b m%b mode%0d line%0d",
                       want.pixel_valid, want.pixel_shade, want.line_done,
                       want.frame_start_vblank, want.line_match, want.mode, want.line);
              $display("         got  v%b s%0d d%b vb%b m%b mode%0d line%0d",
                       out_word.pixel_valid, out_word.pixel_shade, out_word.line_done,
                       out_word.frame_start_vblank, out_word.line_match, out_word.mode,
                       out_word.line);
            end
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

endmodule
